[src/iadp_pkg.sv]
package iadp_pkg;

    localparam int DataWidth  = 32;
    localparam int CharWidth  = 8;
    localparam int MaxDigits  = 10;
    localparam int DigitIdxW  = 4;
    localparam int MsgIdxW    = 5;
    localparam int DivCountW  = 6;

    localparam logic [7:0] OP_ADD = 8'h2B;
    localparam logic [7:0] OP_SUB = 8'h2D;
    localparam logic [7:0] OP_MUL = 8'h2A;
    localparam logic [7:0] OP_DIV = 8'h2F;
    localparam logic [7:0] OP_MOD = 8'h25;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam int DivMsgLen = 23;
    localparam int ModMsgLen = 21;

    // divider command / status between sequencer and divide unit
    typedef struct packed {
        logic                 start;
        logic [DataWidth-1:0] dividend;
        logic [DataWidth-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic                 done;
        logic [DataWidth-1:0] quot;
        logic [DataWidth-1:0] rem;
    } div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_NUM_PREP,
        ST_DIG_START,
        ST_DIG_WAIT,
        ST_SIGN,
        ST_DIGITS,
        ST_MSG,
        ST_NL
    } state_t;

    // "Stop : division by zero"
    function automatic logic [7:0] div_msg_char(input logic [MsgIdxW-1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            5'd0:  c = "S";  5'd1:  c = "t";  5'd2:  c = "o";  5'd3:  c = "p";
            5'd4:  c = " ";  5'd5:  c = ":";  5'd6:  c = " ";  5'd7:  c = "d";
            5'd8:  c = "i";  5'd9:  c = "v";  5'd10: c = "i";  5'd11: c = "s";
            5'd12: c = "i";  5'd13: c = "o";  5'd14: c = "n";  5'd15: c = " ";
            5'd16: c = "b";  5'd17: c = "y";  5'd18: c = " ";  5'd19: c = "z";
            5'd20: c = "e";  5'd21: c = "r";  5'd22: c = "o";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "Stop : modulo by zero"
    function automatic logic [7:0] mod_msg_char(input logic [MsgIdxW-1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            5'd0:  c = "S";  5'd1:  c = "t";  5'd2:  c = "o";  5'd3:  c = "p";
            5'd4:  c = " ";  5'd5:  c = ":";  5'd6:  c = " ";  5'd7:  c = "m";
            5'd8:  c = "o";  5'd9:  c = "d";  5'd10: c = "u";  5'd11: c = "l";
            5'd12: c = "o";  5'd13: c = " ";  5'd14: c = "b";  5'd15: c = "y";
            5'd16: c = " ";  5'd17: c = "z";  5'd18: c = "e";  5'd19: c = "r";
            5'd20: c = "o";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[src/iadp_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle
module iadp_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  iadp_pkg::div_cmd_t   cmd,
    output iadp_pkg::div_stat_t  stat
);
    localparam int W = iadp_pkg::DataWidth;

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [iadp_pkg::DivCountW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]                 quot_reg, quot_next;
    logic [W-1:0]                 rem_reg, rem_next;
    logic [W-1:0]                 dsr_reg, dsr_next;
    logic [W:0]                   trial;
    logic [W:0]                   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quot_reg[W-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = cmd.dividend;
            rem_next  = '0;
            dsr_next  = cmd.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next  = diff[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == iadp_pkg::DivCountW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;
    assign stat.rem  = rem_reg;

endmodule

[src/int_alu_decimal_printer.sv]
// Add/sub/mul/unknown ops compute the value, then convert it to decimal digits by
// repeated division by 10; divide/modulo first add one pass of the shared divider.
// One request at a time: the input is taken only in idle, and a single bit-serial
// divider is used for both the operation and each digit (divide by 10).
// Output: one character per cycle while the consumer is ready.
// Reset: rst_n asynchronous active low returns the sequencer to idle.
module int_alu_decimal_printer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] operand_a, [39:32] operator_code, [71:40] operand_b
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_char
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);
    localparam int W = iadp_pkg::DataWidth;

    iadp_pkg::state_t state_reg, state_next;

    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [7:0]   op_reg, op_next;
    logic [W-1:0] val_reg, val_next;
    logic         neg_reg, neg_next;
    logic [3:0]   digit_reg [iadp_pkg::MaxDigits];
    logic [iadp_pkg::DigitIdxW-1:0] ndig_reg, ndig_next;
    logic [iadp_pkg::MsgIdxW-1:0]   idx_reg, idx_next;
    logic         is_mod_reg, is_mod_next;
    logic         push_digit;

    logic [W-1:0] a_in, b_in;
    logic [7:0]   op_in;
    logic [W-1:0] mag_a, mag_b;
    logic [W-1:0] product;

    iadp_pkg::div_cmd_t  div_cmd;
    iadp_pkg::div_stat_t div_stat;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       out_last_reg, out_last_next;
    logic       out_free;
    logic [iadp_pkg::MsgIdxW-1:0] msg_len;

    assign a_in  = s_axis_tdata[31:0];
    assign op_in = s_axis_tdata[39:32];
    assign b_in  = s_axis_tdata[71:40];

    assign mag_a   = a_reg[W-1] ? (W'(0) - a_reg) : a_reg;
    assign mag_b   = b_reg[W-1] ? (W'(0) - b_reg) : b_reg;
    assign product = a_reg * b_reg;

    assign s_axis_tready = (state_reg == iadp_pkg::ST_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign msg_len       = is_mod_reg ? iadp_pkg::MsgIdxW'(iadp_pkg::ModMsgLen)
                                      : iadp_pkg::MsgIdxW'(iadp_pkg::DivMsgLen);

    iadp_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (div_cmd),
        .stat (div_stat)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iadp_pkg::ST_IDLE:
                if (s_axis_tvalid)
                begin
                    unique case (op_in)
                        iadp_pkg::OP_ADD, iadp_pkg::OP_SUB: state_next = iadp_pkg::ST_NUM_PREP;
                        iadp_pkg::OP_MUL: state_next = iadp_pkg::ST_MUL;
                        iadp_pkg::OP_DIV, iadp_pkg::OP_MOD:
                            state_next = (b_in == '0) ? iadp_pkg::ST_MSG
                                                      : iadp_pkg::ST_DIV_START;
                        default: state_next = iadp_pkg::ST_NUM_PREP;
                    endcase
                end
            iadp_pkg::ST_MUL:       state_next = iadp_pkg::ST_NUM_PREP;
            iadp_pkg::ST_DIV_START: state_next = iadp_pkg::ST_DIV_WAIT;
            iadp_pkg::ST_DIV_WAIT:
                if (div_stat.done) state_next = iadp_pkg::ST_NUM_PREP;
            iadp_pkg::ST_NUM_PREP:  state_next = iadp_pkg::ST_DIG_START;
            iadp_pkg::ST_DIG_START: state_next = iadp_pkg::ST_DIG_WAIT;
            iadp_pkg::ST_DIG_WAIT:
                if (div_stat.done)
                    state_next = (div_stat.quot == '0) ? iadp_pkg::ST_SIGN
                                                       : iadp_pkg::ST_DIG_START;
            iadp_pkg::ST_SIGN:
                if (out_free) state_next = iadp_pkg::ST_DIGITS;
            iadp_pkg::ST_DIGITS:
                if (out_free && ndig_reg == iadp_pkg::DigitIdxW'(1))
                    state_next = iadp_pkg::ST_NL;
            iadp_pkg::ST_MSG:
                if (out_free && idx_reg == msg_len - 1'b1)
                    state_next = iadp_pkg::ST_NL;
            iadp_pkg::ST_NL:
                if (out_free) state_next = iadp_pkg::ST_IDLE;
            default: state_next = iadp_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        a_next         = a_reg;
        b_next         = b_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        neg_next       = neg_reg;
        ndig_next      = ndig_reg;
        idx_next       = idx_reg;
        is_mod_next    = is_mod_reg;
        push_digit     = 1'b0;
        div_cmd        = '0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            iadp_pkg::ST_IDLE:
                if (s_axis_tvalid)
                begin
                    a_next      = a_in;
                    b_next      = b_in;
                    op_next     = op_in;
                    idx_next    = '0;
                    ndig_next   = '0;
                    is_mod_next = (op_in == iadp_pkg::OP_MOD);
                    case (op_in)
                        iadp_pkg::OP_ADD: val_next = a_in + b_in;
                        iadp_pkg::OP_SUB: val_next = a_in - b_in;
                        default:          val_next = '0;
                    endcase
                end
            iadp_pkg::ST_MUL: val_next = product;
            iadp_pkg::ST_DIV_START:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = mag_a;
                div_cmd.divisor  = mag_b;
            end
            iadp_pkg::ST_DIV_WAIT:
                if (div_stat.done)
                begin
                    if (op_reg == iadp_pkg::OP_DIV)
                        val_next = (a_reg[W-1] != b_reg[W-1]) ? (W'(0) - div_stat.quot)
                                                              : div_stat.quot;
                    else
                        val_next = a_reg[W-1] ? (W'(0) - div_stat.rem) : div_stat.rem;
                end
            iadp_pkg::ST_NUM_PREP:
            begin
                neg_next = val_reg[W-1];
                val_next = val_reg[W-1] ? (W'(0) - val_reg) : val_reg;
            end
            iadp_pkg::ST_DIG_START:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = val_reg;
                div_cmd.divisor  = W'(10);
            end
            iadp_pkg::ST_DIG_WAIT:
                if (div_stat.done)
                begin
                    push_digit = 1'b1;
                    ndig_next  = ndig_reg + 1'b1;
                    val_next   = div_stat.quot;
                end
            iadp_pkg::ST_SIGN:
                if (out_free && neg_reg)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = iadp_pkg::CH_MINUS;
                    out_last_next  = 1'b0;
                end
            iadp_pkg::ST_DIGITS:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = iadp_pkg::CH_ZERO +
                                     {4'd0, digit_reg[ndig_reg - 1'b1]};
                    out_last_next  = 1'b0;
                    ndig_next      = ndig_reg - 1'b1;
                end
            iadp_pkg::ST_MSG:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = is_mod_reg ? iadp_pkg::mod_msg_char(idx_reg)
                                                : iadp_pkg::div_msg_char(idx_reg);
                    out_last_next  = 1'b0;
                    idx_next       = idx_reg + 1'b1;
                end
            iadp_pkg::ST_NL:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = iadp_pkg::CH_NL;
                    out_last_next  = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iadp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            ndig_reg      <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ndig_reg      <= ndig_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        op_reg       <= op_next;
        val_reg      <= val_next;
        neg_reg      <= neg_next;
        is_mod_reg   <= is_mod_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        if (push_digit)
            digit_reg[ndig_reg] <= div_stat.rem[3:0];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

    // digit stack never exceeds ten entries
    assert property (@(posedge clk) disable iff (!rst_n)
        ndig_reg <= iadp_pkg::DigitIdxW'(iadp_pkg::MaxDigits))
        else $error("digit count overflow");

    // divider start only from a start state
    assert property (@(posedge clk) disable iff (!rst_n)
        div_cmd.start |-> (state_reg == iadp_pkg::ST_DIV_START ||
                           state_reg == iadp_pkg::ST_DIG_START))
        else $error("stray divider start");

    // a newline sent returns the block to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iadp_pkg::ST_NL && out_free) |=> (state_reg == iadp_pkg::ST_IDLE))
        else $error("no return to idle after newline");

endmodule
